/* design/huffman_tree_decoder_core_assert.svh */
// assertion macros of the huffman tree decoder core
`ifndef HUFFMAN_TREE_DECODER_CORE_ASSERT_SVH
`define HUFFMAN_TREE_DECODER_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define HTD_ASSERT_IMPL(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define HTD_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

/* design/htd_pkg.sv */
// types and constants of the huffman tree decoder
`timescale 1ns / 1ps

package htd_pkg;

	localparam int IDX_W       = 9;
	localparam int SYM_FIELD_W = 8;
	localparam int BYTE_W      = 8;
	localparam int CNT_W       = 4;

	localparam logic [CNT_W-1:0] BYTE_BITS = 4'd8;

	localparam logic FUNC_LOAD   = 1'b0;
	localparam logic FUNC_DECODE = 1'b1;

	typedef struct packed {
		logic                   func;
		logic [IDX_W-1:0]       node_index;
		logic                   node_is_leaf;
		logic [SYM_FIELD_W-1:0] node_symbol;
		logic [IDX_W-1:0]       left_child;
		logic [IDX_W-1:0]       right_child;
		logic [BYTE_W-1:0]      coded_byte;
		logic [CNT_W-1:0]       bit_count;
		logic                   stream_start;
	} in_item_t;

	typedef struct packed {
		logic [SYM_FIELD_W-1:0] symbol;
		logic                   last;
	} out_item_t;

	typedef struct packed {
		logic                   leaf;
		logic [SYM_FIELD_W-1:0] symbol;
		logic [IDX_W-1:0]       left;
		logic [IDX_W-1:0]       right;
	} node_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FLUSH
	} seq_state_t;

	// what the outstanding node read stands for
	typedef enum logic {
		RD_CUR,
		RD_NXT
	} rd_kind_t;

endpackage

/* design/huffman_tree_decoder_core.sv */
// huffman tree walk decoder top level
//
// channel  direction  handshake                    payload
// item     in         item_valid / item_ready      in_item_t (load node or coded byte)
// result   out        result_valid / result_ready  out_item_t (symbol, last)
// cfg      in         cfg_we                       cfg_wdata (root node index)
//
// a node load or a zero-count byte is taken without leaving the idle state
// a coded byte is walked bit by bit, with an extra node read for each bit that starts on a
// freshly read inner node (the first bit and each bit after a symbol), plus accept
// and flush steps, each waiting on the registered node memory read
// no clearing pass after reset: node memory holds garbage until loaded
// a full result register stalls the walk only when a symbol has to move out
`timescale 1ns / 1ps
`include "huffman_tree_decoder_core_assert.svh"

module huffman_tree_decoder_core import htd_pkg::*; #(
	parameter int NODE_COUNT  = 512,
	parameter int SYMBOL_BITS = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  in_item_t         item,
	output logic             result_valid,
	input  logic             result_ready,
	output out_item_t        result,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_wdata
);

	seq_state_t state_q, state_d;

	logic [IDX_W-1:0]       root_q, cur_q;
	logic [BYTE_W-1:0]      bits_q;
	logic [CNT_W-1:0]       cnt_q;
	rd_kind_t               rd_kind_q, rd_kind_d;
	logic [IDX_W-1:0]       rd_idx_q, rd_idx;
	logic                   rd_en;
	node_t                  rd_node, wr_node;
	logic                   hold_vq;
	logic [SYM_FIELD_W-1:0] hold_sym_q;
	out_item_t              out_q;
	logic                   out_vq;

	logic             accept, dec_accept, load_accept;
	logic [CNT_W-1:0] in_cnt;
	logic [IDX_W-1:0] start_idx;
	logic             out_free, emit_ok, more_bits;
	logic             emit, consume, walk_go, go_root, flush_out, out_load;

	// input transfer decode
	assign item_ready  = (state_q == ST_IDLE);
	assign accept      = item_valid && item_ready;
	assign dec_accept  = accept && (item.func == FUNC_DECODE);
	assign load_accept = accept && (item.func == FUNC_LOAD);
	assign in_cnt      = (item.bit_count > BYTE_BITS) ? BYTE_BITS : item.bit_count;
	assign start_idx   = item.stream_start ? root_q : cur_q;

	assign out_free  = !out_vq || result_ready;
	assign emit_ok   = !hold_vq || out_free;
	assign more_bits = cnt_q > CNT_W'(1);

	// node memory
	assign wr_node.leaf   = item.node_is_leaf;
	assign wr_node.symbol = item.node_symbol;
	assign wr_node.left   = item.left_child;
	assign wr_node.right  = item.right_child;

	htd_node_ram #(
		.NODE_COUNT  (NODE_COUNT),
		.SYMBOL_BITS (SYMBOL_BITS)
	) u_node_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (load_accept),
		.wr_idx  (item.node_index),
		.wr_node (wr_node),
		.rd_en   (rd_en),
		.rd_idx  (rd_idx),
		.rd_node (rd_node)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (dec_accept && (in_cnt != '0)) begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				if (consume && !more_bits) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (!hold_vq || out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// walk control and memory read requests
	always_comb begin
		rd_en     = 1'b0;
		rd_idx    = root_q;
		rd_kind_d = RD_CUR;
		emit      = 1'b0;
		consume   = 1'b0;
		walk_go   = 1'b0;
		go_root   = 1'b0;
		flush_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (dec_accept && (in_cnt != '0)) begin
					rd_en  = 1'b1;
					rd_idx = start_idx;
				end
			end
			ST_WALK: begin
				if (rd_node.leaf) begin
					// leaf: emit, back to root, fetch root for the next bit
					if (emit_ok) begin
						emit    = 1'b1;
						consume = 1'b1;
						go_root = 1'b1;
						rd_en   = more_bits;
					end
				end else if (rd_kind_q == RD_CUR) begin
					// inner current node: fetch the child picked by this bit
					rd_en     = 1'b1;
					rd_idx    = bits_q[0] ? rd_node.right : rd_node.left;
					rd_kind_d = RD_NXT;
				end else begin
					// inner child: step onto it and fetch its child for the next bit
					consume   = 1'b1;
					walk_go   = 1'b1;
					rd_en     = more_bits;
					rd_idx    = bits_q[1] ? rd_node.right : rd_node.left;
					rd_kind_d = RD_NXT;
				end
			end
			ST_FLUSH: begin
				flush_out = hold_vq && out_free;
			end
			default: ;
		endcase
	end

	assign out_load = (emit && hold_vq) || flush_out;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			root_q    <= '0;
			cur_q     <= '0;
			cnt_q     <= '0;
			rd_kind_q <= RD_CUR;
			hold_vq   <= 1'b0;
			out_vq    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				root_q <= cfg_wdata;
			end
			if (dec_accept) begin
				cur_q <= start_idx;
			end else if (go_root) begin
				cur_q <= root_q;
			end else if (walk_go) begin
				cur_q <= rd_idx_q;
			end
			if (dec_accept) begin
				cnt_q <= in_cnt;
			end else if (consume) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (rd_en) begin
				rd_kind_q <= rd_kind_d;
			end
			if (emit) begin
				hold_vq <= 1'b1;
			end else if (flush_out) begin
				hold_vq <= 1'b0;
			end
			if (out_load) begin
				out_vq <= 1'b1;
			end else if (result_ready) begin
				out_vq <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (dec_accept) begin
			bits_q <= item.coded_byte;
		end else if (consume) begin
			bits_q <= bits_q >> 1;
		end
		if (rd_en) begin
			rd_idx_q <= rd_idx;
		end
		if (emit) begin
			hold_sym_q <= rd_node.symbol;
		end
		// held symbol leaves as last only on the end-of-byte flush
		if (out_load) begin
			out_q.symbol <= hold_sym_q;
			out_q.last   <= flush_out;
		end
	end

	assign result_valid = out_vq;
	assign result       = out_q;

	`HTD_ASSERT_IMPL(a_walk_has_bits, state_q == ST_WALK, cnt_q != '0, "walk with no bits left")
	`HTD_ASSERT_IMPL(a_idle_hold_empty, state_q == ST_IDLE, !hold_vq, "symbol held while idle")
	`HTD_ASSERT_NEXT(a_load_keeps_walk, load_accept, $stable(cur_q), "node load moved the walk")
	`HTD_ASSERT_NEXT(a_flush_done, state_q == ST_FLUSH && !hold_vq, state_q == ST_IDLE, "flush stuck")

endmodule

/* design/htd_node_ram.sv */
// node memory of the code tree with range check on both ports
`timescale 1ns / 1ps

module htd_node_ram import htd_pkg::*; #(
	parameter int NODE_COUNT  = 512,
	parameter int SYMBOL_BITS = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_idx,
	input  node_t            wr_node,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_idx,
	output node_t            rd_node
);

	localparam int AW    = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
	localparam int CW    = ((AW > IDX_W) ? AW : IDX_W) + 1;
	localparam int SW    = (SYMBOL_BITS < SYM_FIELD_W) ? SYMBOL_BITS : SYM_FIELD_W;
	localparam int ENT_W = 1 + SW + 2 * IDX_W;

	logic [ENT_W-1:0] mem [NODE_COUNT];

	logic [CW-1:0]    wr_ext, rd_ext;
	logic             wr_in_range, rd_in_range;
	logic [ENT_W-1:0] wr_word, rd_word_q;
	logic             rd_oob_q;

	// index range checks
	assign wr_ext      = CW'(wr_idx);
	assign rd_ext      = CW'(rd_idx);
	assign wr_in_range = wr_ext < CW'(NODE_COUNT);
	assign rd_in_range = rd_ext < CW'(NODE_COUNT);

	assign wr_word = {wr_node.leaf, wr_node.symbol[SW-1:0], wr_node.left, wr_node.right};

	// write port, out of range loads dropped
	always_ff @(posedge clk) begin
		if (wr_en && wr_in_range) begin
			mem[wr_ext[AW-1:0]] <= wr_word;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_word_q <= mem[rd_ext[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_oob_q <= 1'b0;
		end else if (rd_en) begin
			rd_oob_q <= !rd_in_range;
		end
	end

	// out of range reads give an inner node with both children zero
	always_comb begin
		if (rd_oob_q) begin
			rd_node = '0;
		end else begin
			rd_node.leaf   = rd_word_q[ENT_W-1];
			rd_node.symbol = SYM_FIELD_W'(rd_word_q[2*IDX_W +: SW]);
			rd_node.left   = rd_word_q[IDX_W +: IDX_W];
			rd_node.right  = rd_word_q[0 +: IDX_W];
		end
	end

endmodule

/* tb/tb_huffman_tree_decoder_core.sv */
// self-checking testbench for the huffman tree walk decoder top level
`timescale 1ns / 1ps

module tb_huffman_tree_decoder_core;
	import htd_pkg::*;

	localparam int CLK_PERIOD    = 10;
	localparam int RESET_CYCLES  = 9;
	localparam int NODE_COUNT    = 512;
	localparam int SYMBOL_BITS   = 8;
	localparam int MAX_GAP       = 6;
	localparam int SETTLE_CYCLES = 30;
	localparam int HOLD_CYCLES   = 250;
	localparam int MAX_REPORTS   = 10;
	localparam int TREE_MAX      = 32;
	localparam int CYCLE_LIMIT   = 200000;

	logic             clk          = 1'b0;
	logic             arst_n       = 1'b0;
	logic             item_valid   = 1'b0;
	logic             item_ready;
	in_item_t         item         = '0;
	logic             result_valid;
	logic             result_ready = 1'b0;
	out_item_t        result;
	logic             cfg_we       = 1'b0;
	logic [IDX_W-1:0] cfg_wdata    = '0;

	// predictor state: node memory copy, walk position and root register
	node_t            tree_copy [0:NODE_COUNT-1];
	logic [IDX_W-1:0] walk_pos;
	logic [IDX_W-1:0] root_reg;
	out_item_t        symbols_due [$];

	int unsigned pending_gap = 0;
	bit          offer_up    = 1'b0;
	bit          burst_mode  = 1'b0;
	int unsigned hold_req    = 0;
	int unsigned hold_left   = 0;
	int unsigned ready_wait  = 0;
	int unsigned error_count = 0;
	int unsigned cycle_count = 0;
	out_item_t   want;

	huffman_tree_decoder_core #(
		.NODE_COUNT  (NODE_COUNT),
		.SYMBOL_BITS (SYMBOL_BITS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_huffman_tree_decoder_core: FAIL");
			$finish;
		end
	end

	function automatic int unsigned draw_gap();
		return burst_mode ? 0 : $urandom_range(0, MAX_GAP);
	endfunction

	// walk the tree copy for one accepted item and queue the symbols it emits
	task automatic predict_symbols(input in_item_t it);
		node_t            cur;
		node_t            nxt;
		logic [IDX_W-1:0] nxt_idx;
		logic [CNT_W-1:0] count;
		out_item_t        batch [$];
		out_item_t        sym_out;
		bit               emit;
		if (it.func == FUNC_LOAD) begin
			tree_copy[it.node_index].leaf   = it.node_is_leaf;
			tree_copy[it.node_index].symbol = it.node_symbol;
			tree_copy[it.node_index].left   = it.left_child;
			tree_copy[it.node_index].right  = it.right_child;
			return;
		end
		count = (it.bit_count > BYTE_BITS) ? BYTE_BITS : it.bit_count;
		if (it.stream_start)
			walk_pos = root_reg;
		for (int i = 0; i < count; i++) begin
			cur  = tree_copy[walk_pos];
			emit = 1'b0;
			if (cur.leaf) begin
				// leaf root: each bit yields the root symbol
				emit = 1'b1;
				sym_out.symbol = cur.symbol;
			end else begin
				nxt_idx = it.coded_byte[i] ? cur.right : cur.left;
				nxt     = tree_copy[nxt_idx];
				if (nxt.leaf) begin
					emit = 1'b1;
					sym_out.symbol = nxt.symbol;
				end else begin
					walk_pos = nxt_idx;
				end
			end
			if (emit) begin
				walk_pos     = root_reg;
				sym_out.last = 1'b0;
				batch.push_back(sym_out);
			end
		end
		if (batch.size() > 0)
			batch[batch.size() - 1].last = 1'b1;
		foreach (batch[k])
			symbols_due.push_back(batch[k]);
	endtask

	function automatic in_item_t random_item();
		logic [63:0] noise;
		noise = {$urandom, $urandom};
		return noise[$bits(in_item_t)-1:0];
	endfunction

	function automatic in_item_t node_load(input logic [IDX_W-1:0] idx, input logic leaf,
			input logic [SYM_FIELD_W-1:0] sym, input logic [IDX_W-1:0] lc,
			input logic [IDX_W-1:0] rc);
		in_item_t it;
		it              = random_item();
		it.func         = FUNC_LOAD;
		it.node_index   = idx;
		it.node_is_leaf = leaf;
		it.node_symbol  = sym;
		it.left_child   = lc;
		it.right_child  = rc;
		return it;
	endfunction

	function automatic in_item_t byte_decode(input logic [BYTE_W-1:0] bits,
			input logic [CNT_W-1:0] count, input logic start);
		in_item_t it;
		it              = random_item();
		it.func         = FUNC_DECODE;
		it.coded_byte   = bits;
		it.bit_count    = count;
		it.stream_start = start;
		return it;
	endfunction

	// offer one item and wait for its transfer; valid stays up if the next gap is zero
	task automatic send_item(input in_item_t it);
		if (pending_gap > 0)
			repeat (pending_gap) @(posedge clk);
		item       <= it;
		item_valid <= 1'b1;
		offer_up   = 1'b1;
		do
			@(posedge clk);
		while (!item_ready);
		predict_symbols(it);
		pending_gap = draw_gap();
		if (pending_gap > 0) begin
			item_valid <= 1'b0;
			offer_up   = 1'b0;
		end
	endtask

	// stop offering, wait for all symbols, then let in-flight work finish
	task automatic drain_results();
		if (offer_up) begin
			item_valid <= 1'b0;
			offer_up   = 1'b0;
		end
		while (symbols_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_root_node(input logic [IDX_W-1:0] value);
		drain_results();
		cfg_wdata <= value;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we   <= 1'b0;
		root_reg = value;
	endtask

	// result side: random ready gaps and the long hold-off
	always @(posedge clk) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req  = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else if (result_valid && result_ready) begin
				ready_wait = draw_gap();
				result_ready <= (ready_wait == 0);
			end else if (ready_wait > 0) begin
				ready_wait--;
				result_ready <= (ready_wait == 0);
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// compare each symbol transfer with the oldest expected one
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (symbols_due.size() == 0) begin
				if (error_count < MAX_REPORTS)
					$display("%0t unexpected symbol: got symbol %02h last %0b",
						$time, result.symbol, result.last);
				error_count++;
			end else begin
				want = symbols_due.pop_front();
				if (result.symbol !== want.symbol || result.last !== want.last) begin
					if (error_count < MAX_REPORTS)
						$display("%0t symbol mismatch: expected %02h last %0b, got %02h last %0b",
							$time, want.symbol, want.last, result.symbol, result.last);
					error_count++;
				end
			end
		end
	end

	// hand-built tree over the index extremes: 0 -> (1, 511), 511 -> (2, 3)
	task automatic test_directed_codes();
		in_item_t it;
		set_root_node(9'd0);
		send_item(node_load(9'd0, 1'b0, 8'h00, 9'd1, 9'd511));
		send_item(node_load(9'd1, 1'b1, 8'h00, 9'd0, 9'd0));
		send_item(node_load(9'd511, 1'b0, 8'hFF, 9'd2, 9'd3));
		send_item(node_load(9'd2, 1'b1, 8'hFF, 9'd511, 9'd511));
		// stream start on a load is ignored
		it = node_load(9'd3, 1'b1, 8'h81, 9'd0, 9'd511);
		it.stream_start = 1'b1;
		send_item(it);
		send_item(byte_decode(8'h00, BYTE_BITS, 1'b1));
		send_item(byte_decode(8'hFF, BYTE_BITS, 1'b0));
		// zero bit count and counts above eight
		send_item(byte_decode(8'hA5, 4'd0, 1'b0));
		send_item(byte_decode(8'h5A, 4'd15, 1'b0));
		send_item(byte_decode(8'h5A, 4'd9, 1'b0));
		// code split across bytes, then a restart that drops a partial code
		send_item(byte_decode(8'h01, 4'd1, 1'b0));
		send_item(byte_decode(8'h00, 4'd1, 1'b0));
		send_item(byte_decode(8'h01, 4'd1, 1'b0));
		send_item(byte_decode(8'h06, 4'd3, 1'b1));
		// root moved mid code: the old code completes first
		send_item(byte_decode(8'h01, 4'd1, 1'b0));
		set_root_node(9'd511);
		send_item(byte_decode(8'hC4, BYTE_BITS, 1'b0));
		// leaf root
		set_root_node(9'd2);
		send_item(byte_decode(8'h3C, BYTE_BITS, 1'b1));
		send_item(byte_decode(8'hFF, BYTE_BITS, 1'b0));
		set_root_node(9'd0);
	endtask

	// receiver holds off while short codes fill the block
	task automatic test_result_backpressure();
		hold_req = HOLD_CYCLES;
		send_item(byte_decode(8'h00, BYTE_BITS, 1'b1));
		repeat (5) send_item(byte_decode(8'h00, BYTE_BITS, 1'b0));
		drain_results();
	endtask

	// no gaps on either side
	task automatic test_back_to_back();
		logic [31:0] r;
		burst_mode = 1'b1;
		for (int k = 0; k < 16; k++) begin
			r = $urandom;
			send_item(byte_decode(r[7:0], BYTE_BITS, k == 0));
		end
		drain_results();
		burst_mode = 1'b0;
	endtask

	// random full binary tree scattered over memory, then coded bytes with some noise
	task automatic run_tree_phase(input int leaves, input int bytes);
		logic [IDX_W-1:0] slot     [0:TREE_MAX-1];
		int               left_of  [0:TREE_MAX-1];
		int               right_of [0:TREE_MAX-1];
		bit               leaf_of  [0:TREE_MAX-1];
		bit               taken    [0:NODE_COUNT-1];
		int               open_ids [$];
		int               used;
		int               pick;
		int               parent;
		int               roll;
		logic [31:0]      r;
		in_item_t         it;
		used = 1;
		open_ids.push_back(0);
		while (open_ids.size() < leaves) begin
			pick   = $urandom_range(0, open_ids.size() - 1);
			parent = open_ids[pick];
			open_ids.delete(pick);
			left_of[parent]  = used;
			right_of[parent] = used + 1;
			open_ids.push_back(used);
			open_ids.push_back(used + 1);
			used += 2;
		end
		foreach (open_ids[k])
			leaf_of[open_ids[k]] = 1'b1;
		for (int k = 0; k < used; k++) begin
			do
				r = $urandom;
			while (taken[r[IDX_W-1:0]]);
			taken[r[IDX_W-1:0]] = 1'b1;
			slot[k] = r[IDX_W-1:0];
		end
		// node loads; leaves keep random child fields
		for (int k = 0; k < used; k++) begin
			it              = random_item();
			it.func         = FUNC_LOAD;
			it.node_index   = slot[k];
			it.node_is_leaf = leaf_of[k];
			if (!leaf_of[k]) begin
				it.left_child  = slot[left_of[k]];
				it.right_child = slot[right_of[k]];
			end
			send_item(it);
		end
		set_root_node(slot[0]);
		for (int b = 0; b < bytes; b++) begin
			it      = random_item();
			it.func = FUNC_DECODE;
			roll    = $urandom_range(0, 99);
			if (roll < 8) begin
				// stray node write anywhere off the live tree
				it.func = FUNC_LOAD;
				do
					r = $urandom;
				while (taken[r[IDX_W-1:0]]);
				it.node_index = r[IDX_W-1:0];
			end else if (roll < 16) begin
				// random count and restart as drawn
			end else if (roll < 22) begin
				it.bit_count    = BYTE_BITS;
				it.stream_start = 1'b1;
			end else begin
				it.bit_count    = BYTE_BITS;
				it.stream_start = 1'b0;
			end
			if (b == 0) begin
				it.func         = FUNC_DECODE;
				it.stream_start = 1'b1;
			end
			send_item(it);
		end
	endtask

	task automatic test_random_trees();
		for (int p = 0; p < 5; p++)
			run_tree_phase((p == 2) ? 1 : $urandom_range(2, 12), 14);
		drain_results();
	endtask

	initial begin
		foreach (tree_copy[i])
			tree_copy[i] = '0;
		walk_pos = '0;
		root_reg = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_codes();
		test_result_backpressure();
		test_back_to_back();
		test_random_trees();
		drain_results();
		if (error_count == 0 && symbols_due.size() == 0)
			$display("tb_huffman_tree_decoder_core: PASS");
		else
			$display("tb_huffman_tree_decoder_core: FAIL");
		$finish;
	end

endmodule
